>>> src/saa_pkg.sv
package saa_pkg;

  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned USED_W = 17;
  localparam int unsigned CFG_W  = 17;

  typedef enum logic [1:0] {
    CMD_ALLOC_ITEM  = 2'd0,
    CMD_ALLOC_ARRAY = 2'd1,
    CMD_FREE        = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_en;
    logic alloc;
    logic release_blk;
    logic rd_top;
    logic step_top;
    logic load_used;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic pop_done;
  } stat_t;

endpackage

>>> src/saa_ctrl.sv
module saa_ctrl import saa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy,
  output logic  result_strobe_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ALLOC,
    ST_FREE,
    ST_POP_CHK,
    ST_POP_BELOW,
    ST_POP_SIZE
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;

  always_comb begin
    ctrl_o   = '0;
    state_d  = state_q;
    strobe_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_en = 1'b1;
        case (stat_i.cmd)
          CMD_ALLOC_ITEM, CMD_ALLOC_ARRAY: state_d = ST_ALLOC;
          CMD_FREE:                        state_d = ST_FREE;
          default: begin
            ctrl_o.emit = 1'b1;
            strobe_d    = 1'b1;
            state_d     = ST_IDLE;
          end
        endcase
      end
      ST_ALLOC: begin
        ctrl_o.alloc = 1'b1;
        strobe_d     = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FREE: begin
        ctrl_o.release_blk = 1'b1;
        state_d            = ST_POP_CHK;
      end
      ST_POP_CHK: begin
        if (stat_i.pop_done) begin
          ctrl_o.emit = 1'b1;
          strobe_d    = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ctrl_o.rd_top = 1'b1;
          state_d       = ST_POP_BELOW;
        end
      end
      ST_POP_BELOW: begin
        ctrl_o.step_top = 1'b1;
        state_d         = ST_POP_SIZE;
      end
      ST_POP_SIZE: begin
        ctrl_o.load_used = 1'b1;
        state_d          = ST_POP_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;

endmodule

>>> src/saa_datapath.sv
module saa_datapath import saa_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic [1:0]        command_i,
  input  logic [SIZE_W-1:0] item_size_i,
  input  logic [SIZE_W-1:0] item_count_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  arena_size_i,
  output logic              status_o,
  output logic [ADDR_W-1:0] data_address_o,
  output logic [USED_W-1:0] used_bytes_o
);

  localparam int unsigned SLOT_COUNT = ARENA_BYTES / HEADER_BYTES;
  localparam int unsigned SW         = $clog2(SLOT_COUNT);
  localparam int unsigned UW         = $clog2(SLOT_COUNT + 1);
  localparam int unsigned HW         = $clog2(HEADER_BYTES) + 1;
  localparam int unsigned XW         = SIZE_W + 1;
  localparam int unsigned K          = XW + $clog2(HEADER_BYTES);
  localparam int unsigned MW         = XW + 1;
  localparam int unsigned SUMW       = ((UW > XW) ? UW : XW) + 1;
  localparam int unsigned PW         = SUMW + HW;
  localparam int unsigned MAX_USED   = (ARENA_BYTES - 1) / HEADER_BYTES;
  localparam longint unsigned RECIP  =
    ((longint'(1) << K) + longint'(HEADER_BYTES) - 1) / longint'(HEADER_BYTES);

  localparam logic [PW-1:0]     HDR       = PW'(HEADER_BYTES);
  localparam logic [XW-1:0]     HDR_M1    = XW'(HEADER_BYTES - 1);
  localparam logic [MW-1:0]     RECIP_C   = MW'(RECIP);
  localparam logic [CFG_W-1:0]  ARENA_LIM = CFG_W'(ARENA_BYTES);

  cmd_e              cmd_q;
  logic [SIZE_W-1:0] isz_q, cnt_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CFG_W-1:0]  arena_q;
  logic [2*SIZE_W-1:0] prod_q;
  logic              over_q;
  logic [XW-1:0]     quot_q;
  logic [SW-1:0]     top_q;
  logic [UW-1:0]     used_q;
  logic              slot0_q;
  logic [SW-1:0]     below_rd_q;
  logic [UW-1:0]     size_rd_q;
  logic              size_zero_q;
  logic              status_q;
  logic [ADDR_W-1:0] data_q;
  logic [USED_W-1:0] used_bytes_q;

  logic [UW-1:0] size_mem  [SLOT_COUNT];
  logic [SW-1:0] below_mem [SLOT_COUNT];

  logic [CFG_W-1:0]    limit;
  logic [2*SIZE_W-1:0] prod_d;
  logic [XW-1:0]       div_x;
  logic [K+XW-1:0]     div_p;
  logic [SUMW-1:0]     nslots;
  logic [SUMW-1:0]     end_slots;
  logic [PW-1:0]       end_bytes;
  logic [PW-1:0]       cur_bytes;
  logic [PW-1:0]       data_bytes;
  logic [PW-1:0]       quot_bytes;
  logic                fit;
  logic                free_ok;
  logic [SW-1:0]       free_slot;
  logic                size_we;
  logic [SW-1:0]       size_waddr;
  logic [UW-1:0]       size_wdata;
  logic                below_we;

  always_comb begin
    limit = (32'(arena_q) < 32'(ARENA_BYTES)) ? arena_q : ARENA_LIM;

    case (cmd_q)
      CMD_ALLOC_ARRAY: prod_d = (2*SIZE_W)'(isz_q) * (2*SIZE_W)'(cnt_q);
      CMD_FREE:        prod_d = (2*SIZE_W)'(addr_q);
      default:         prod_d = (2*SIZE_W)'(isz_q);
    endcase

    div_x = (cmd_q == CMD_FREE) ? XW'(addr_q) : (XW'(prod_q[SIZE_W-1:0]) + HDR_M1);
    div_p = (K+XW)'(div_x) * (K+XW)'(RECIP_C);

    nslots     = SUMW'(quot_q) + SUMW'(1);
    end_slots  = SUMW'(used_q) + nslots;
    end_bytes  = PW'(end_slots) * HDR;
    cur_bytes  = PW'(used_q) * HDR;
    data_bytes = PW'(SUMW'(used_q) + SUMW'(1)) * HDR;
    fit        = !over_q && (32'(used_q) < 32'(MAX_USED)) && (end_bytes <= PW'(limit));

    quot_bytes = PW'(quot_q) * HDR;
    free_ok    = (quot_q != '0) && (quot_bytes == PW'(addr_q))
                 && (32'(quot_q) <= 32'(SLOT_COUNT));
    free_slot  = SW'(quot_q - XW'(1));

    size_we    = (ctrl_i.alloc && fit) || (ctrl_i.release_blk && free_ok);
    size_waddr = ctrl_i.alloc ? SW'(used_q) : free_slot;
    size_wdata = ctrl_i.alloc ? UW'(nslots) : '0;
    below_we   = ctrl_i.alloc && fit;
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.pop_done = (top_q == '0) || (UW'(top_q) != used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= CFG_W'(65536);
      top_q   <= '0;
      used_q  <= '0;
      slot0_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= arena_size_i;
      end
      if (size_we && (size_waddr == '0)) begin
        slot0_q <= 1'b1;
      end
      if (ctrl_i.alloc && fit) begin
        top_q  <= SW'(used_q);
        used_q <= UW'(end_slots);
      end
      if (ctrl_i.release_blk && free_ok && (free_slot == top_q)) begin
        used_q <= UW'(top_q);
      end
      if (ctrl_i.step_top) begin
        top_q <= below_rd_q;
      end
      if (ctrl_i.load_used) begin
        used_q <= UW'(top_q) + (size_zero_q ? UW'(0) : size_rd_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      isz_q  <= item_size_i;
      cnt_q  <= item_count_i;
      addr_q <= address_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.div_en) begin
      quot_q <= div_p[K +: XW];
      over_q <= (prod_q > (2*SIZE_W)'(limit));
    end
    if (ctrl_i.alloc) begin
      status_q     <= !fit;
      data_q       <= fit ? data_bytes[ADDR_W-1:0] : '0;
      used_bytes_q <= fit ? end_bytes[USED_W-1:0] : cur_bytes[USED_W-1:0];
    end
    if (ctrl_i.emit) begin
      status_q     <= 1'b0;
      data_q       <= '0;
      used_bytes_q <= cur_bytes[USED_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    if (ctrl_i.step_top) begin
      size_rd_q   <= size_mem[below_rd_q];
      size_zero_q <= (below_rd_q == '0) && !slot0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (below_we) begin
      below_mem[SW'(used_q)] <= top_q;
    end
    if (ctrl_i.rd_top) begin
      below_rd_q <= below_mem[top_q];
    end
  end

  assign status_o       = status_q;
  assign data_address_o = data_q;
  assign used_bytes_o   = used_bytes_q;

endmodule

>>> src/stack_arena_allocator.sv
// Channel   Direction  Transfer condition           Payload
// command   in         start && !busy               command_i, item_size_i, item_count_i,
//                                                   address_i
// result    out        result_strobe_o (one cycle)  status_o, data_address_o, used_bytes_o
// config    in         cfg_valid_i && cfg_ready_o   arena_size_i
//
// Allocation runs through latch, size multiply, reciprocal divide by the header
// size, then the fit check and header write; the strobe follows in the next cycle.
// A free latches, multiplies and divides, releases the header, then pops blocks; each pop
// reads the link memory, then the size memory. An unknown command ends after the divide.
// Reset clears the top pointer, used count and slot-zero mark; no memory sweep runs.
// The result is not stalled: it is shown for one cycle and must be taken.
module stack_arena_allocator import saa_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic [SIZE_W-1:0] item_size_i,
  input  logic [SIZE_W-1:0] item_count_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic              result_strobe_o,
  output logic              status_o,
  output logic [ADDR_W-1:0] data_address_o,
  output logic [USED_W-1:0] used_bytes_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  arena_size_i
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  saa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .stat_i          (stat),
    .ctrl_o          (ctrl),
    .busy            (busy),
    .result_strobe_o (result_strobe_o)
  );

  saa_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (command_i),
    .item_size_i    (item_size_i),
    .item_count_i   (item_count_i),
    .address_i      (address_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .arena_size_i   (arena_size_i),
    .status_o       (status_o),
    .data_address_o (data_address_o),
    .used_bytes_o   (used_bytes_o)
  );

endmodule

>>> tb/sv/stack_arena_allocator_test.sv
`timescale 1ns / 100ps

module stack_arena_allocator_test import saa_pkg::*; ();

  localparam int unsigned HDR_BYTES       = 16;
  localparam int unsigned ARENA_MAX       = 65536;
  localparam int unsigned SLOTS           = ARENA_MAX / HDR_BYTES;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 1000000;

  typedef enum logic [1:0] {
    BLK_CLEAR = 2'd0,
    BLK_ITEM  = 2'd1,
    BLK_ARRAY = 2'd2
  } blk_kind_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] count;
    logic [ADDR_W-1:0] addr;
  } op_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] data_addr;
    logic [USED_W-1:0] used;
  } outcome_t;

  typedef struct packed {
    op_t      op;
    logic     typed;
    outcome_t want;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        command_i;
  logic [SIZE_W-1:0] item_size_i;
  logic [SIZE_W-1:0] item_count_i;
  logic [ADDR_W-1:0] address_i;
  logic              result_strobe_o;
  logic              status_o;
  logic [ADDR_W-1:0] data_address_o;
  logic [USED_W-1:0] used_bytes_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  arena_size_i;

  stack_arena_allocator DUT (.*);

  logic [SIZE_W-1:0] hdr_size  [SLOTS];
  logic [11:0]       hdr_below [SLOTS];
  blk_kind_e         hdr_kind  [SLOTS];
  logic [SIZE_W-1:0] hdr_count [SLOTS];
  logic [11:0]       stack_top;
  logic [CFG_W-1:0]  arena_limit;
  logic [ADDR_W-1:0] live_blocks [$];

  outcome_t pending_outcomes [$];
  outcome_t oldest;
  logic [CFG_W-1:0] arena_plan [PHASES];

  int  cycle_count = 0;
  int  error_count = 0;
  int  n_sent, n_granted, n_refused, n_frees, n_cfg, deepest;
  bit  idle_on;

  directed_row_t directed_rows [24] = '{
    '{'{CMD_ALLOC_ITEM,  17'd0,     17'd0,     16'd0},     1'b1, '{1'b0, 16'd16, 17'd16}},
    '{'{CMD_ALLOC_ITEM,  17'd1,     17'd0,     16'd0},     1'b0, '0},
    '{'{CMD_ALLOC_ARRAY, 17'd3,     17'd5,     16'd0},     1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd0},     1'b1, '{1'b0, 16'd0, 17'd80}},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd8},     1'b1, '{1'b0, 16'd0, 17'd80}},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd33},    1'b1, '{1'b0, 16'd0, 17'd80}},
    '{'{CMD_NONE,        17'd5,     17'd5,     16'd64},    1'b1, '{1'b0, 16'd0, 17'd80}},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd32},    1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd64},    1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd4000},  1'b0, '0},
    '{'{CMD_ALLOC_ITEM,  17'd65536, 17'd0,     16'd0},     1'b1, '{1'b1, 16'd0, 17'd16}},
    '{'{CMD_ALLOC_ARRAY, 17'd65536, 17'd65536, 16'd0},     1'b1, '{1'b1, 16'd0, 17'd16}},
    '{'{CMD_ALLOC_ARRAY, 17'd65535, 17'd0,     16'd0},     1'b0, '0},
    '{'{CMD_ALLOC_ARRAY, 17'd0,     17'd65536, 16'd0},     1'b0, '0},
    '{'{CMD_ALLOC_ITEM,  17'd65472, 17'd0,     16'd0},     1'b1, '{1'b0, 16'd64, 17'd65536}},
    '{'{CMD_ALLOC_ITEM,  17'd0,     17'd0,     16'd0},     1'b1, '{1'b1, 16'd0, 17'd65536}},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd16},    1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd64},    1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd48},    1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd32},    1'b1, '{1'b0, 16'd0, 17'd0}},
    '{'{CMD_ALLOC_ITEM,  17'd100,   17'd0,     16'd0},     1'b1, '{1'b0, 16'd16, 17'd128}},
    '{'{CMD_ALLOC_ARRAY, 17'd1,     17'd65536, 16'd0},     1'b1, '{1'b1, 16'd0, 17'd128}},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd65520}, 1'b0, '0},
    '{'{CMD_FREE,        17'd0,     17'd0,     16'd16},    1'b1, '{1'b0, 16'd0, 17'd0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outcomes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  function automatic longint unsigned arena_used();
    longint unsigned top_bytes;
    top_bytes = 64'(stack_top);
    return top_bytes * HDR_BYTES + 64'(hdr_size[stack_top]);
  endfunction

  function automatic logic [ADDR_W-1:0] push_block(input longint unsigned nbytes,
                                                   input blk_kind_e kind,
                                                   input logic [SIZE_W-1:0] n);
    longint unsigned rounded, base, total, lim;
    logic [11:0] slot;
    rounded = (nbytes + HDR_BYTES - 1) / HDR_BYTES * HDR_BYTES;
    base    = arena_used();
    total   = rounded + HDR_BYTES;
    lim     = (arena_limit < ARENA_MAX) ? 64'(arena_limit) : 64'(ARENA_MAX);
    if (base + total > lim || base + HDR_BYTES >= ARENA_MAX) return '0;
    slot = 12'(base / HDR_BYTES);
    hdr_size[slot]  = SIZE_W'(total);
    hdr_below[slot] = stack_top;
    hdr_kind[slot]  = kind;
    hdr_count[slot] = n;
    stack_top       = slot;
    live_blocks.push_back(ADDR_W'(base + HDR_BYTES));
    if (live_blocks.size() > deepest) deepest = live_blocks.size();
    return ADDR_W'(base + HDR_BYTES);
  endfunction

  function automatic void drop_block(input logic [ADDR_W-1:0] addr);
    logic [11:0] slot;
    if (addr < HDR_BYTES || addr % HDR_BYTES != 0) return;
    slot = 12'(addr / HDR_BYTES - 1);
    hdr_size[slot]  = '0;
    hdr_kind[slot]  = BLK_CLEAR;
    hdr_count[slot] = '0;
    for (int i = 0; i < live_blocks.size(); i++) begin
      if (live_blocks[i] == addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    for (int g = 0; g < SLOTS; g++) begin
      if (stack_top == 0 || hdr_size[stack_top] != 0) break;
      stack_top = hdr_below[stack_top];
    end
  endfunction

  function automatic outcome_t predict_arena_op(input op_t o);
    outcome_t r;
    longint unsigned product;
    r = '0;
    case (o.cmd)
      CMD_ALLOC_ITEM: begin
        r.data_addr = push_block(64'(o.size), BLK_ITEM, '0);
        r.status    = (r.data_addr == 0);
      end
      CMD_ALLOC_ARRAY: begin
        product     = 64'(o.size);
        product     = product * 64'(o.count);
        r.data_addr = push_block(product, BLK_ARRAY, o.count);
        r.status    = (r.data_addr == 0);
      end
      CMD_FREE: begin
        drop_block(o.addr);
        n_frees++;
      end
      default: ;
    endcase
    if (o.cmd inside {CMD_ALLOC_ITEM, CMD_ALLOC_ARRAY}) begin
      if (r.status) n_refused++;
      else n_granted++;
    end
    r.used = USED_W'(arena_used());
    return r;
  endfunction

  function automatic op_t random_op();
    op_t o;
    int unsigned pick;
    o.cmd   = CMD_ALLOC_ITEM;
    o.size  = SIZE_W'($urandom_range(0, 65536));
    o.count = SIZE_W'($urandom_range(0, 65536));
    o.addr  = ADDR_W'($urandom_range(0, 65535));
    pick    = $urandom_range(0, 99);
    if (pick < 30) begin
      o.size = SIZE_W'($urandom_range(0, 48));
    end else if (pick < 42) begin
      o.size = SIZE_W'($urandom_range(0, 1500));
    end else if (pick < 52) begin
      o.cmd   = CMD_ALLOC_ARRAY;
      o.size  = SIZE_W'($urandom_range(0, 24));
      o.count = SIZE_W'($urandom_range(0, 6));
    end else if (pick < 85 && live_blocks.size() != 0) begin
      o.cmd  = CMD_FREE;
      o.addr = $urandom_range(0, 1) ? live_blocks[$]
                                    : live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    end else begin
      case ($urandom_range(0, 4))
        0: ;
        1: o.cmd = CMD_ALLOC_ARRAY;
        2: o.cmd = CMD_NONE;
        3: o.cmd = CMD_FREE;
        default: begin
          o.cmd  = CMD_FREE;
          o.addr = ADDR_W'($urandom_range(1, SLOTS - 1) * HDR_BYTES);
        end
      endcase
    end
    return o;
  endfunction

  task automatic send_op(input op_t o, input logic typed, input outcome_t want);
    outcome_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    command_i    <= o.cmd;
    item_size_i  <= o.size;
    item_count_i <= o.count;
    address_i    <= o.addr;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = predict_arena_op(o);
    pending_outcomes.push_back(typed ? want : got);
    n_sent++;
  endtask

  task automatic write_arena_size(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 17)) @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    arena_size_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    arena_limit = value;
    n_cfg++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unrequested result, data_address", data_address_o, 0);
      end else begin
        oldest = pending_outcomes.pop_front();
        if (status_o !== oldest.status)
          report_mismatch("status", status_o, oldest.status);
        if (data_address_o !== oldest.data_addr)
          report_mismatch("data_address", data_address_o, oldest.data_addr);
        if (used_bytes_o !== oldest.used)
          report_mismatch("used_bytes", used_bytes_o, oldest.used);
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    command_i    <= CMD_NONE;
    item_size_i  <= '0;
    item_count_i <= '0;
    address_i    <= '0;
    cfg_valid_i  <= 1'b0;
    arena_size_i <= '0;
    for (int s = 0; s < SLOTS; s++) begin
      hdr_size[s]  = '0;
      hdr_below[s] = '0;
      hdr_kind[s]  = BLK_CLEAR;
      hdr_count[s] = '0;
    end
    stack_top   = '0;
    arena_limit = 17'd65536;
    idle_on     = 1'b1;
    arena_plan  = '{17'd65536, 17'd16, 17'd4096, 17'($urandom_range(16, 65536)),
                    17'd1000, 17'd65536};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      write_arena_size(arena_plan[p]);
      idle_on = (p != PHASES - 1);
      repeat (ITEMS_PER_PHASE) send_op(random_op(), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d commands: %0d allocations granted, %0d refused, %0d frees",
             n_sent, n_granted, n_refused, n_frees);
    $display("arena size written %0d times, stack reached %0d live blocks", n_cfg, deepest);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
